// ----- rtl/signed_integer_to_radix_digits_assert.svh -----
// Assertion macros used by the RTL of the radix text block.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SITRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/sitrd_pkg.sv -----
`timescale 1ns / 1ps
package sitrd_pkg;

   localparam int VALUE_BITS      = 63;
   localparam int RADIX_BITS      = 6;
   localparam int DIGIT_BITS      = 5;
   localparam int CHAR_BITS       = 8;
   localparam int STACK_DEPTH     = 64;
   localparam int STACK_ADDR_BITS = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS      = STACK_ADDR_BITS + 1;
   localparam int STEP_BITS       = $clog2(VALUE_BITS);

   localparam logic [RADIX_BITS-1:0] MIN_RADIX  = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] MAX_RADIX  = RADIX_BITS'(32);
   localparam logic [CHAR_BITS-1:0]  MINUS_CODE = CHAR_BITS'(8'h2D);
   localparam logic [CHAR_BITS-1:0]  ERROR_CODE = CHAR_BITS'(8'h00);
   localparam logic [CHAR_BITS-1:0]  ZERO_CODE  = CHAR_BITS'(8'h30);
   localparam logic [CHAR_BITS-1:0]  ALPHA_BASE = CHAR_BITS'(8'h37);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOAD = 6'b000010,
      S_WAIT = 6'b000100,
      S_SIGN = 6'b001000,
      S_READ = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] code;
      if (d < DIGIT_BITS'(10)) begin
         code = ZERO_CODE + CHAR_BITS'(d);
      end else begin
         code = ALPHA_BASE + CHAR_BITS'(d);
      end
      return code;
   endfunction

endpackage

// ----- rtl/sitrd_div.sv -----
`timescale 1ns / 1ps
module sitrd_div import sitrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] divisor,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_BITS-1:0] remainder,
   output div_status_type        status
);

   logic [VALUE_BITS-1:0] work_ff, work_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] dvs_ff, dvs_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIGIT_BITS:0]   trial;
   logic                  fits;
   logic [DIGIT_BITS:0]   diff;

   // One bit of restoring division per cycle: the dividend shifts out at the
   // top while quotient bits enter at the bottom of the same register.
   always_comb begin
      trial = {rem_ff, work_ff[VALUE_BITS-1]};
      fits  = (trial >= (DIGIT_BITS+1)'(dvs_ff));
      diff  = trial - (DIGIT_BITS+1)'(dvs_ff);
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_BITS'(VALUE_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign quotient    = work_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- rtl/sitrd_stack.sv -----
`timescale 1ns / 1ps
module sitrd_stack import sitrd_pkg::*; (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [STACK_ADDR_BITS-1:0] wr_addr,
   input  logic [DIGIT_BITS-1:0]      wr_data,
   input  logic                       rd_en,
   input  logic [STACK_ADDR_BITS-1:0] rd_addr,
   output logic [DIGIT_BITS-1:0]      rd_data
);

   logic [DIGIT_BITS-1:0] mem [STACK_DEPTH];
   logic [DIGIT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/signed_integer_to_radix_digits.sv -----
`timescale 1ns / 1ps
// Converts a signed integer to ASCII text in a radix from 2 to 32, one character per
// output word, most significant first, with a leading '-' for negative values and last
// set on the final character; a radix outside 2..32 gives a single word with bad_radix
// set. Each digit comes from one pass of the shared bit-serial divider and is pushed
// onto the digit stack memory; each character is then read back from that memory
// (S_READ) and emitted (S_EMIT), waiting while the output is stalled. A new word is
// accepted only once the previous item has been emitted and the output register is free.
module signed_integer_to_radix_digits import sitrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_BITS-1:0] req_radix,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_BITS-1:0]  rsp_char_code,
   output logic                  rsp_last,
   output logic                  rsp_bad_radix
);

`include "signed_integer_to_radix_digits_assert.svh"

   state_type                  state_ff, state_in;
   logic [VALUE_BITS-1:0]      quot_ff, quot_in;
   logic [RADIX_BITS-1:0]      radix_ff, radix_in;
   logic                       neg_ff, neg_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [STACK_ADDR_BITS-1:0] idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_bad_ff, rsp_bad_in;

   logic                       req_fire;
   logic                       out_free;
   logic                       radix_ok;
   logic                       in_neg;
   logic [VALUE_BITS-1:0]      in_mag;
   logic                       div_start;
   logic [VALUE_BITS-1:0]      div_quot;
   logic [DIGIT_BITS-1:0]      div_rem;
   div_status_type             div_stat;
   logic                       stk_wr;
   logic                       stk_rd;
   logic [DIGIT_BITS-1:0]      stk_data;

   sitrd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (quot_ff),
      .divisor   (radix_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .status    (div_stat)
   );

   sitrd_stack u_stack (
      .clock   (clock),
      .wr_en   (stk_wr),
      .wr_addr (count_ff[STACK_ADDR_BITS-1:0]),
      .wr_data (div_rem),
      .rd_en   (stk_rd),
      .rd_addr (idx_ff),
      .rd_data (stk_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign radix_ok  = req_radix inside {[MIN_RADIX:MAX_RADIX]};
   assign in_neg    = req_value[VALUE_BITS-1];
   assign in_mag    = in_neg ? (~req_value + VALUE_BITS'(1)) : req_value;
   assign div_start = (state_ff == S_LOAD);

   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      stk_wr       = 1'b0;
      stk_rd       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!radix_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ERROR_CODE;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = 1'b1;
               end else begin
                  quot_in  = in_mag;
                  radix_in = req_radix;
                  neg_in   = in_neg;
                  count_in = '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_stat.done) begin
               stk_wr   = 1'b1;
               quot_in  = div_quot;
               count_in = count_ff + COUNT_BITS'(1);
               idx_in   = count_ff[STACK_ADDR_BITS-1:0];
               if ((div_quot == '0) || (count_ff == COUNT_BITS'(STACK_DEPTH - 1))) begin
                  state_in = S_SIGN;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_SIGN: begin
            if (!neg_ff) begin
               state_in = S_READ;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = MINUS_CODE;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            stk_rd   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(stk_data);
               rsp_last_in  = (idx_ff == '0);
               rsp_bad_in   = 1'b0;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - STACK_ADDR_BITS'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         quot_ff      <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         quot_ff      <= quot_in;
         neg_ff       <= neg_in;
      end
      radix_ff    <= radix_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   `SITRD_ASSERT_NEXT(a_bad_radix_word, clock, reset, req_fire && !radix_ok,
      rsp_valid && rsp_bad_radix && rsp_last && (rsp_char_code == ERROR_CODE))
   `SITRD_ASSERT_NOW(a_idle_divider_quiet, clock, reset, req_ready, !div_stat.busy)
   `SITRD_ASSERT_NOW(a_stack_in_range, clock, reset, state_ff == S_WAIT,
      count_ff < COUNT_BITS'(STACK_DEPTH))
   `SITRD_ASSERT_NOW(a_done_only_waiting, clock, reset, div_stat.done, state_ff == S_WAIT)

endmodule
